// ===== rtl/fnsp_pkg.sv =====
// fnsp_pkg: shared types and constants of the next-slot predictor
// used by fnsp_cell and frequency_next_slot_predictor_core; no dependencies
`default_nettype none

package fnsp_pkg;

    localparam logic [7:0] NO_SLOT = 8'hFF;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_RESET   = 2'd1;
    localparam logic [1:0] CMD_CONSUME = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BUSY
    } state_t;

    // running best candidate handed from cell to cell
    typedef struct packed {
        logic [31:0] count;
        logic [31:0] tick;
        logic [7:0]  idx;
        logic [7:0]  excl;
    } cand_t;

endpackage

`default_nettype wire

// ===== rtl/frequency_next_slot_predictor_core.sv =====
// frequency_next_slot_predictor_core: top level of the next-slot predictor
// depends on fnsp_pkg and fnsp_cell
//
// usage
// - input channel in_valid/in_ready carries command, slot, tick, pages_free
// - output channel out_valid/out_ready carries one result item per input item
// - a load, or a reset of the predicted slot, runs a scan through the row of
//   SLOTS cells, one cell per cycle; the result is offered once the scan has
//   passed the last cell
// - every other item (consume, other resets, slot out of range, command 3)
//   needs no scan; its result is registered once the item is registered
// - one item at a time: in_ready is high only while no item is in progress,
//   so a new item is not taken until the last has finished; the length of
//   the cell row sets the scan time
// - a finished result is held in the output register while the receiver
//   stalls; the next item may be taken meanwhile but completes only once the
//   held result has been taken
// - reset clears all use counts, ticks and totals, the prediction becomes
//   none (255), and out_valid goes low
`default_nettype none

module frequency_next_slot_predictor_core #(
    parameter int unsigned SLOTS   = 16,
    parameter int unsigned RESERVE = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  slot,
    input  logic [31:0] tick,
    input  logic [7:0]  pages_free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [7:0]  next_slot,
    output logic        reservation_active,
    output logic [2:0]  reserved_pages,
    output logic [31:0] hit_count,
    output logic [31:0] miss_count,
    output logic [31:0] prediction_count
);
    import fnsp_pkg::*;

    localparam int unsigned CNT_W = $clog2(SLOTS + 1);
    localparam int unsigned HW    = $clog2(RESERVE + 1);
    localparam logic [CNT_W-1:0] CNT_LIM  = CNT_W'(SLOTS);
    localparam logic [7:0]       SLOT_LIM = 8'(SLOTS);
    localparam logic [7:0]       RES8     = 8'(RESERVE);

    state_t state_reg, state_next;

    logic [1:0]       cmd_reg;
    logic [7:0]       slot_reg;
    logic [7:0]       pages_reg;
    logic [7:0]       excl_reg;
    logic             scan_reg;
    logic             range_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       last_loaded_reg;

    logic [7:0]    pred_reg, pred_next;
    logic          active_reg, active_next;
    logic [HW-1:0] held_reg, held_next;
    logic [31:0]   hits_reg, hits_next;
    logic [31:0]   misses_reg, misses_next;
    logic [31:0]   preds_reg, preds_next;
    logic          hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;

    logic          accept;
    logic          in_range;
    logic          need_scan;
    logic          done;
    logic          fin;
    logic [HW-1:0] take_n;
    logic [7:0]    p;
    logic [HW+2:0] held_ext;

    cand_t chain [SLOTS+1];

    assign accept    = in_valid && in_ready;
    assign in_range  = slot < SLOT_LIM;
    assign need_scan = in_range && ((command == CMD_LOAD) ||
                       ((command == CMD_RESET) && (slot == pred_reg)));

    // seed of the cell row
    assign chain[0].count = '0;
    assign chain[0].tick  = '0;
    assign chain[0].idx   = NO_SLOT;
    assign chain[0].excl  = excl_reg;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        fnsp_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bump     (accept && in_range && (command == CMD_LOAD) && (slot == 8'(i))),
            .tick     (tick),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1])
        );
    end

    assign p      = chain[SLOTS].idx;
    assign take_n = (pages_reg < RES8) ? pages_reg[HW-1:0] : HW'(RESERVE);
    assign done   = !scan_reg || (cnt_reg == CNT_LIM);
    assign fin    = (state_reg == ST_BUSY) && done && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            slot_reg  <= slot;
            pages_reg <= pages_free;
            range_reg <= in_range;
            excl_reg  <= (command == CMD_LOAD) ? slot : last_loaded_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            scan_reg        <= 1'b0;
            cnt_reg         <= '0;
            last_loaded_reg <= NO_SLOT;
            pred_reg        <= NO_SLOT;
            active_reg      <= 1'b0;
            held_reg        <= '0;
            hits_reg        <= '0;
            misses_reg      <= '0;
            preds_reg       <= '0;
            hit_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pred_reg      <= pred_next;
            active_reg    <= active_next;
            held_reg      <= held_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            preds_reg     <= preds_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                scan_reg <= need_scan;
                cnt_reg  <= '0;
                if (in_range && (command == CMD_LOAD))
                begin
                    last_loaded_reg <= slot;
                end
            end
            else if ((state_reg == ST_BUSY) && !done)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pred_next      = pred_reg;
        active_next    = active_reg;
        held_next      = held_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        preds_next     = preds_reg;
        hit_next       = hit_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        in_ready       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (fin)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    if (range_reg)
                    begin
                        case (cmd_reg)
                            CMD_LOAD:
                            begin
                                if ((p != pred_reg) && (p != NO_SLOT))
                                begin
                                    pred_next   = p;
                                    preds_next  = preds_reg + 32'd1;
                                    held_next   = take_n;
                                    active_next = (take_n != '0);
                                end
                                else if (p == NO_SLOT)
                                begin
                                    pred_next   = NO_SLOT;
                                    held_next   = '0;
                                    active_next = 1'b0;
                                end
                            end
                            CMD_RESET:
                            begin
                                if (scan_reg)
                                begin
                                    pred_next   = p;
                                    held_next   = '0;
                                    active_next = 1'b0;
                                    if (p != NO_SLOT)
                                    begin
                                        preds_next  = preds_reg + 32'd1;
                                        held_next   = take_n;
                                        active_next = (take_n != '0);
                                    end
                                end
                            end
                            CMD_CONSUME:
                            begin
                                if (active_reg && (slot_reg == pred_reg))
                                begin
                                    hit_next    = 1'b1;
                                    hits_next   = hits_reg + 32'd1;
                                    active_next = 1'b0;
                                    held_next   = '0;
                                end
                                else if (active_reg)
                                begin
                                    misses_next = misses_reg + 32'd1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign held_ext = {3'b000, held_reg};

    assign out_valid          = out_valid_reg;
    assign hit                = hit_reg;
    assign next_slot          = pred_reg;
    assign reservation_active = active_reg;
    assign reserved_pages     = held_ext[2:0];
    assign hit_count          = hits_reg;
    assign miss_count         = misses_reg;
    assign prediction_count   = preds_reg;

`ifndef SYNTHESIS
    a_active_has_pages: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (held_reg != '0))
        else $error("reservation active with no pages held");

    a_pred_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pred_reg == NO_SLOT) || (pred_reg < SLOT_LIM))
        else $error("prediction outside slot range");

    a_state_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=>
            ($stable(pred_reg) && $stable(held_reg) && $stable(preds_reg)))
        else $error("state changed while result stalled");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUSY) |-> (cnt_reg <= CNT_LIM))
        else $error("scan counter overran cell row");

    a_hit_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && hit_next) |=> (!active_reg && (held_reg == '0)))
        else $error("hit left reservation active");
`endif

endmodule

`default_nettype wire

// ===== rtl/fnsp_cell.sv =====
// fnsp_cell: one slot of the predictor, holding its use count and last tick
// and passing on the better of its own entry and the incoming candidate
// depends on fnsp_pkg
`default_nettype none

module fnsp_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            bump,
    input  logic [31:0]     tick,
    input  fnsp_pkg::cand_t cand_in,
    output fnsp_pkg::cand_t cand_out
);
    import fnsp_pkg::*;

    localparam logic [7:0] MY_IDX = 8'(IDX);

    logic [31:0] count_reg;
    logic [31:0] tick_reg;
    cand_t       cand_reg;
    cand_t       cand_next;
    logic        better;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tick_reg  <= '0;
        end
        else if (bump)
        begin
            count_reg <= count_reg + 32'd1;
            tick_reg  <= tick;
        end
    end

    always_comb
    begin
        better = (count_reg != 32'd0) && (MY_IDX != cand_in.excl) &&
                 ((count_reg > cand_in.count) ||
                  ((count_reg == cand_in.count) && (tick_reg > cand_in.tick)));
        cand_next = cand_in;
        if (better)
        begin
            cand_next.count = count_reg;
            cand_next.tick  = tick_reg;
            cand_next.idx   = MY_IDX;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    assign cand_out = cand_reg;

endmodule

`default_nettype wire
